@@ hdl/srx_pkg.sv @@
// Shared constants and controller/datapath interface types for the serial frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package srx_pkg;

    // Storage sizing
    localparam int BUFFER_DEPTH_DEF = 64;
    localparam int MAX_BURST        = 64;

    // Frame terminator (newline)
    localparam logic [7:0] TERMINATOR = 8'h0A;

    // Configuration register indexes
    localparam int          CFG_IDX_W         = 3;
    localparam logic [2:0]  CFG_START_BYTE    = 3'd0;
    localparam logic [2:0]  CFG_COMMAND_MASK  = 3'd1;
    localparam logic [2:0]  CFG_COMMAND_MATCH = 3'd2;
    localparam logic [2:0]  CFG_MAX_PAYLOAD   = 3'd3;

    // Configuration reset values
    localparam logic [7:0] START_BYTE_RST    = 8'hAA;
    localparam logic [7:0] COMMAND_MASK_RST  = 8'hF0;
    localparam logic [7:0] COMMAND_MATCH_RST = 8'h80;
    localparam logic [6:0] MAX_PAYLOAD_RST   = 7'd48;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_cmd;    // capture command byte
        logic start_len;   // capture length, clear sum and position
        logic data_wr;     // store payload byte, add to sum, advance position
        logic load_sumh;   // capture checksum high byte
        logic load_suml;   // capture checksum low byte
        logic emit_start;  // rewind position for the output burst
        logic emit_rd;     // read store at current position
        logic emit_load;   // load output register, advance position
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic start_hit;
        logic cmd_ok;
        logic len_ok;
        logic len_zero;
        logic data_done;
        logic term_hit;
        logic emit_last;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

@@ hdl/serial_frame_receiver_unit.sv @@
// Top level of the serial frame receiver: controller, datapath and configuration port.
`timescale 1ns / 1ps
`default_nettype none

// Serial frame receiver. Bytes are taken one per cycle while framing: start byte,
// command (masked compare), length (at most max_payload and the buffer depth),
// payload, checksum high then low, and a newline terminator with at most one stray
// byte before it. At the terminator the input stalls and the frame is sent out as
// one transaction per payload byte (one transaction for an empty frame). Each output
// transaction is a read of the registered-read payload store followed by a load of
// the output register; the load waits while that register holds a result that
// downstream stalls. The last result may wait in the output register while the
// next frame is already being received. The payload store needs no clearing after
// reset. Configuration writes are always ready; indexes beyond the register list are
// ignored.
module serial_frame_receiver_unit #(
    parameter int BUFFER_DEPTH = srx_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [7:0]                    i_byte_in,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [7:0]                         o_command,
    output logic [6:0]                         o_payload_length,
    output logic [7:0]                         o_payload_byte,
    output logic [5:0]                         o_payload_index,
    output logic                               o_last,
    output logic                               o_checksum_error,
    output logic [15:0]                        o_computed_sum,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [srx_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                    i_cfg_data
);

    import srx_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    // Sequencer
    srx_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Datapath
    srx_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_byte_in        (i_byte_in),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_command        (o_command),
        .o_payload_length (o_payload_length),
        .o_payload_byte   (o_payload_byte),
        .o_payload_index  (o_payload_index),
        .o_last           (o_last),
        .o_checksum_error (o_checksum_error),
        .o_computed_sum   (o_computed_sum)
    );

endmodule

`default_nettype wire

@@ hdl/srx_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module srx_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/srx_ctrl.sv @@
// Frame parsing and output burst state machine.
`timescale 1ns / 1ps
`default_nettype none

module srx_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire srx_pkg::t_dp_status  i_status,
    output srx_pkg::t_dp_cmd          o_cmd
);

    import srx_pkg::*;

    typedef enum logic [3:0] {
        S_HUNT,
        S_CMD,
        S_LEN,
        S_DATA,
        S_SUMH,
        S_SUML,
        S_END0,
        S_END1,
        S_EMIT_RD,
        S_EMIT_WR
    } t_state;

    t_state r_state, n_state;
    logic   r_stall, n_stall;
    logic   acc;

    assign acc     = i_valid && !r_stall;
    assign o_stall = r_stall;

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_HUNT: begin
                if (acc && i_status.start_hit) n_state = S_CMD;
            end
            S_CMD: begin
                if (acc) begin
                    if (i_status.cmd_ok) begin
                        o_cmd.load_cmd = 1'b1;
                        n_state        = S_LEN;
                    end else begin
                        n_state = S_HUNT;
                    end
                end
            end
            S_LEN: begin
                if (acc) begin
                    if (i_status.len_ok) begin
                        o_cmd.start_len = 1'b1;
                        n_state         = i_status.len_zero ? S_SUMH : S_DATA;
                    end else begin
                        n_state = S_HUNT;
                    end
                end
            end
            S_DATA: begin
                if (acc) begin
                    o_cmd.data_wr = 1'b1;
                    if (i_status.data_done) n_state = S_SUMH;
                end
            end
            S_SUMH: begin
                if (acc) begin
                    o_cmd.load_sumh = 1'b1;
                    n_state         = S_SUML;
                end
            end
            S_SUML: begin
                if (acc) begin
                    o_cmd.load_suml = 1'b1;
                    n_state         = S_END0;
                end
            end
            S_END0, S_END1: begin
                if (acc) begin
                    if (i_status.term_hit) begin
                        o_cmd.emit_start = 1'b1;
                        n_state          = S_EMIT_RD;
                    end else begin
                        // one stray byte is tolerated before the terminator
                        n_state = (r_state == S_END0) ? S_END1 : S_HUNT;
                    end
                end
            end
            S_EMIT_RD: begin
                o_cmd.emit_rd = 1'b1;
                n_state       = S_EMIT_WR;
            end
            S_EMIT_WR: begin
                if (i_status.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    n_state         = i_status.emit_last ? S_HUNT : S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_HUNT;
            end
        endcase
    end

    // Input is held off for the whole output burst
    assign n_stall = (n_state inside {S_EMIT_RD, S_EMIT_WR});

    // State and registered stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= n_stall;
        end
    end

endmodule

`default_nettype wire

@@ hdl/srx_dp.sv @@
// Datapath: configuration registers, frame fields, checksum, payload store and output register.
`timescale 1ns / 1ps
`default_nettype none

module srx_dp #(
    parameter int BUFFER_DEPTH = srx_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [7:0]                i_byte_in,
    input  wire logic                      i_cfg_valid,
    input  wire logic [srx_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                i_cfg_data,
    input  wire srx_pkg::t_dp_cmd          i_cmd,
    output srx_pkg::t_dp_status            o_status,
    input  wire logic                      i_stall,
    output logic                           o_valid,
    output logic [7:0]                     o_command,
    output logic [6:0]                     o_payload_length,
    output logic [7:0]                     o_payload_byte,
    output logic [5:0]                     o_payload_index,
    output logic                           o_last,
    output logic                           o_checksum_error,
    output logic [15:0]                    o_computed_sum
);

    import srx_pkg::*;

    // Usable depth: a frame never carries more than MAX_BURST bytes
    localparam int EFF_DEPTH = (BUFFER_DEPTH < MAX_BURST) ? BUFFER_DEPTH : MAX_BURST;
    localparam int AW        = (EFF_DEPTH > 1) ? $clog2(EFF_DEPTH) : 1;

    logic [7:0]  r_start, r_mask, r_match;
    logic [6:0]  r_maxp;
    logic [7:0]  r_cmd;
    logic [6:0]  r_len;
    logic [6:0]  r_pos;
    logic [15:0] r_sum;
    logic [15:0] r_rsum;
    logic        r_out_valid;
    logic [7:0]  ram_rdata;
    logic [7:0]  pos_inc;
    logic [7:0]  burst_cnt;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= START_BYTE_RST;
            r_mask  <= COMMAND_MASK_RST;
            r_match <= COMMAND_MATCH_RST;
            r_maxp  <= MAX_PAYLOAD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_BYTE:    r_start <= i_cfg_data;
                CFG_COMMAND_MASK:  r_mask  <= i_cfg_data;
                CFG_COMMAND_MATCH: r_match <= i_cfg_data;
                CFG_MAX_PAYLOAD:   r_maxp  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Frame fields, position counter and running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd  <= '0;
            r_len  <= '0;
            r_pos  <= '0;
            r_sum  <= '0;
            r_rsum <= '0;
        end else begin
            if (i_cmd.load_cmd) r_cmd <= i_byte_in;
            if (i_cmd.start_len) begin
                r_len <= i_byte_in[6:0];
                r_sum <= '0;
                r_pos <= '0;
            end
            if (i_cmd.data_wr) begin
                r_sum <= r_sum + {8'd0, i_byte_in};
                r_pos <= pos_inc[6:0];
            end
            if (i_cmd.load_sumh) r_rsum <= {i_byte_in, 8'd0};
            if (i_cmd.load_suml) r_rsum <= {r_rsum[15:8], i_byte_in};
            if (i_cmd.emit_start) r_pos <= '0;
            if (i_cmd.emit_load)  r_pos <= pos_inc[6:0];
        end
    end

    // Payload store
    srx_ram #(
        .WIDTH (8),
        .DEPTH (EFF_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.data_wr),
        .i_waddr (r_pos[AW-1:0]),
        .i_wdata (i_byte_in),
        .i_re    (i_cmd.emit_rd),
        .i_raddr (r_pos[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Status toward the controller
    assign pos_inc   = {1'b0, r_pos} + 8'd1;
    assign burst_cnt = (r_len == 7'd0) ? 8'd1 : {1'b0, r_len};

    always_comb begin
        o_status.start_hit = (i_byte_in == r_start);
        o_status.cmd_ok    = ((i_byte_in & r_mask) == r_match);
        o_status.len_ok    = (i_byte_in <= {1'b0, r_maxp}) && (i_byte_in <= 8'(EFF_DEPTH));
        o_status.len_zero  = (i_byte_in == 8'd0);
        o_status.data_done = (pos_inc >= {1'b0, r_len});
        o_status.term_hit  = (i_byte_in == TERMINATOR);
        o_status.emit_last = (pos_inc >= burst_cnt);
        o_status.out_free  = !r_out_valid || !i_stall;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            o_command        <= r_cmd;
            o_payload_length <= r_len;
            o_payload_byte   <= (r_len == 7'd0) ? 8'd0 : ram_rdata;
            o_payload_index  <= r_pos[5:0];
            o_last           <= o_status.emit_last;
            o_checksum_error <= (r_rsum != r_sum);
            o_computed_sum   <= r_sum;
        end
    end

    assign o_valid = r_out_valid;

    // A payload index always lies inside its frame
    a_index_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_payload_length != 7'd0) |->
            ({1'b0, o_payload_index} < o_payload_length))
        else $error("payload index beyond frame length");

    // The last result of a non-empty frame carries the final index
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_last && o_payload_length != 7'd0) |->
            ({1'b0, o_payload_index} == o_payload_length - 7'd1))
        else $error("last flag not on final payload byte");

    // An empty frame gives a single zero result
    a_empty_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_payload_length == 7'd0) |->
            (o_last && o_payload_byte == 8'd0 && o_payload_index == 6'd0))
        else $error("empty frame result malformed");

endmodule

`default_nettype wire

@@ tb/sv/serial_frame_receiver_unit_tb.sv @@
// Self-checking testbench for the serial frame receiver: directed frame table, then random frames.
`timescale 1ns / 1ps

module serial_frame_receiver_unit_tb;
    import srx_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 400;   // long downstream hold-off
    localparam int IDLE_SLACK   = 8;     // settle time before a register write
    localparam int DRAIN_CYCLES = 200;   // watch for stray results at the end
    localparam int BUF_DEPTH    = BUFFER_DEPTH_DEF;

    // Register indexes past the map; writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

    // Receiver stall patterns
    localparam int STALL_NONE     = 0;
    localparam int STALL_LIGHT    = 1;
    localparam int STALL_PERIODIC = 2;
    localparam int STALL_HEAVY    = 3;

    typedef struct packed {
        logic [7:0]  command;
        logic [6:0]  payload_length;
        logic [7:0]  payload_byte;
        logic [5:0]  payload_index;
        logic        last;
        logic        checksum_error;
        logic [15:0] computed_sum;
    } t_frame_result;

    typedef struct packed {
        logic [7:0]    rx_byte;
        logic          typed;
        t_frame_result res;
    } t_stim_row;

    typedef enum logic [2:0] {
        RX_HUNT,
        RX_CMD,
        RX_LEN,
        RX_DATA,
        RX_SUM_HI,
        RX_SUM_LO,
        RX_TERM,
        RX_TERM_STRAY
    } t_rx_phase;

    localparam t_frame_result NO_RESULT = '0;

    // DUT signals
    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    logic [7:0]           i_byte_in   = 8'h00;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    logic [7:0]           o_command;
    logic [6:0]           o_payload_length;
    logic [7:0]           o_payload_byte;
    logic [5:0]           o_payload_index;
    logic                 o_last;
    logic                 o_checksum_error;
    logic [15:0]          o_computed_sum;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data  = 8'h00;

    // Predictor copy of the registers and the framing state
    logic [7:0]  cfg_start       = START_BYTE_RST;
    logic [7:0]  cfg_mask        = COMMAND_MASK_RST;
    logic [7:0]  cfg_match       = COMMAND_MATCH_RST;
    logic [6:0]  cfg_max_payload = MAX_PAYLOAD_RST;
    t_rx_phase   rx_phase        = RX_HUNT;
    logic [6:0]  rx_pos          = '0;
    logic [6:0]  rx_len          = '0;
    logic [7:0]  rx_cmd          = '0;
    logic [15:0] rx_sum          = '0;
    logic [15:0] rx_got          = '0;
    logic [7:0]  rx_store [BUF_DEPTH];

    t_frame_result frame_burst [$];
    t_frame_result pending_payload_results [$];

    int mismatches       = 0;
    int cycle_count      = 0;
    int frame_bytes_sent = 0;
    int burst_left       = 0;
    int hold_requests    = 0;
    int hold_served      = 0;
    int hold_left        = 0;
    int stall_mode       = STALL_NONE;
    int mode_left        = 0;
    int pattern_count    = 0;

    // Directed frames under the reset configuration
    t_stim_row directed_rows [0:27] = '{
        // empty frame, checksum 0x1234 against a sum of 0
        '{8'hAA, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h12, 1'b0, NO_RESULT},
        '{8'h34, 1'b0, NO_RESULT},
        '{8'h0A, 1'b1, '{8'h80, 7'd0, 8'h00, 6'd0, 1'b1, 1'b1, 16'h0000}},
        // two bytes 0xFF, 0x00, good checksum, one stray byte before the newline
        '{8'hAA, 1'b0, NO_RESULT},
        '{8'h8F, 1'b0, NO_RESULT},
        '{8'h02, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'h5A, 1'b0, NO_RESULT},
        '{8'h0A, 1'b0, NO_RESULT},
        // command fails the mask, then a length one past the limit
        '{8'hAA, 1'b0, NO_RESULT},
        '{8'h70, 1'b0, NO_RESULT},
        '{8'hAA, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, NO_RESULT},
        '{8'h31, 1'b0, NO_RESULT},
        // two stray bytes drop the frame; the newline lands in hunt
        '{8'hAA, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h12, 1'b0, NO_RESULT},
        '{8'h34, 1'b0, NO_RESULT},
        '{8'h55, 1'b0, NO_RESULT},
        '{8'h66, 1'b0, NO_RESULT},
        '{8'h0A, 1'b0, NO_RESULT}
    };

    serial_frame_receiver_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_byte_in        (i_byte_in),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_command        (o_command),
        .o_payload_length (o_payload_length),
        .o_payload_byte   (o_payload_byte),
        .o_payload_index  (o_payload_index),
        .o_last           (o_last),
        .o_checksum_error (o_checksum_error),
        .o_computed_sum   (o_computed_sum),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Advance the framing state by one byte; a newline that closes a frame fills frame_burst
    task automatic deframe_byte(input logic [7:0] b);
        t_frame_result r;
        int count;
        int k;
        frame_burst.delete();
        case (rx_phase)
            RX_HUNT: begin
                if (b == cfg_start) rx_phase = RX_CMD;
            end
            RX_CMD: begin
                if ((b & cfg_mask) == cfg_match) begin
                    rx_cmd   = b;
                    rx_phase = RX_LEN;
                end else begin
                    rx_phase = RX_HUNT;
                end
            end
            RX_LEN: begin
                if (b <= {1'b0, cfg_max_payload} && int'(b) <= BUF_DEPTH
                        && int'(b) <= MAX_BURST) begin
                    rx_len   = b[6:0];
                    rx_sum   = '0;
                    rx_pos   = '0;
                    rx_phase = (b != 8'h00) ? RX_DATA : RX_SUM_HI;
                end else begin
                    rx_phase = RX_HUNT;
                end
            end
            RX_DATA: begin
                rx_store[rx_pos[5:0]] = b;
                rx_sum = rx_sum + {8'h00, b};
                rx_pos = rx_pos + 7'd1;
                if (rx_pos >= rx_len) rx_phase = RX_SUM_HI;
            end
            RX_SUM_HI: begin
                rx_got   = {b, 8'h00};
                rx_phase = RX_SUM_LO;
            end
            RX_SUM_LO: begin
                rx_got[7:0] = b;
                rx_phase    = RX_TERM;
            end
            default: begin
                // terminator, with room for a single stray byte
                if (b == TERMINATOR) begin
                    count = (rx_len != 7'd0) ? int'(rx_len) : 1;
                    for (k = 0; k < count; k++) begin
                        r.command        = rx_cmd;
                        r.payload_length = rx_len;
                        r.payload_byte   = (rx_len != 7'd0) ? rx_store[k] : 8'h00;
                        r.payload_index  = 6'(k);
                        r.last           = (k == count - 1);
                        r.checksum_error = (rx_got != rx_sum);
                        r.computed_sum   = rx_sum;
                        frame_burst.push_back(r);
                    end
                    rx_phase = RX_HUNT;
                end else begin
                    rx_phase = (rx_phase == RX_TERM) ? RX_TERM_STRAY : RX_HUNT;
                end
            end
        endcase
    endtask

    // Offer one byte in bursts with random gaps; predict once the transaction completes
    task automatic send_byte(input logic [7:0] b, input logic typed,
                             input t_frame_result typed_res);
        int gap;
        if (burst_left == 0) begin
            burst_left = int'($urandom_range(1, 24));
            gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 6));
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid   <= 1'b1;
        i_byte_in <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        deframe_byte(b);
        if (typed) begin
            pending_payload_results.push_back(typed_res);
        end else begin
            foreach (frame_burst[k]) pending_payload_results.push_back(frame_burst[k]);
        end
    endtask

    // One register write; the caller lowers valid after the last write of a group
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_START_BYTE:    cfg_start       = data;
            CFG_COMMAND_MASK:  cfg_mask        = data;
            CFG_COMMAND_MATCH: cfg_match       = data;
            CFG_MAX_PAYLOAD:   cfg_max_payload = data[6:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [7:0] start, input logic [7:0] mask,
                                input logic [7:0] match, input logic [7:0] max_len);
        write_reg(CFG_START_BYTE, start);
        write_reg(CFG_COMMAND_MASK, mask);
        write_reg(CFG_COMMAND_MATCH, match);
        write_reg(CFG_MAX_PAYLOAD, max_len);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop sending and let every outstanding result drain
    task automatic wait_for_results(input int slack);
        i_valid <= 1'b0;
        while (pending_payload_results.size() != 0) @(posedge i_clk);
        repeat (slack) @(posedge i_clk);
    endtask

    // One frame with random content; mostly well formed, some broken, a little line noise
    task automatic send_random_frame(input logic at_limit);
        logic [7:0]  cmd;
        logic [7:0]  len;
        logic [7:0]  b;
        logic [7:0]  stray;
        logic [15:0] sum;
        logic [15:0] sent_sum;
        logic [7:0]  frame_q [$];
        int kind;
        int eff_max;
        int n_data;
        eff_max = (int'(cfg_max_payload) < BUF_DEPTH) ? int'(cfg_max_payload) : BUF_DEPTH;
        kind = at_limit ? 0 : int'($urandom_range(0, 99));
        if (kind >= 95) begin
            // noise between frames does not count toward the budget
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0, NO_RESULT);
            return;
        end
        cmd = (8'($urandom) & ~cfg_mask) | (cfg_match & cfg_mask);
        if (kind >= 88 && kind < 91) cmd = 8'($urandom);
        if (at_limit) begin
            len = 8'(eff_max);
        end else if (kind >= 91) begin
            len = 8'($urandom_range(eff_max + 1, 255));
        end else begin
            case ($urandom_range(0, 9))
                0:       len = 8'(eff_max);
                1:       len = 8'($urandom_range(0, eff_max));
                default: len = 8'($urandom_range(0, (eff_max < 6) ? eff_max : 6));
            endcase
        end
        n_data = (int'(len) <= eff_max) ? int'(len) : int'($urandom_range(0, 4));
        sum = '0;
        frame_q.push_back(cfg_start);
        frame_q.push_back(cmd);
        frame_q.push_back(len);
        repeat (n_data) begin
            b   = 8'($urandom);
            sum = sum + {8'h00, b};
            frame_q.push_back(b);
        end
        sent_sum = sum;
        if (kind >= 65 && kind < 75) begin
            sent_sum = 16'($urandom);
            if (sent_sum == sum) sent_sum = ~sum;
        end
        frame_q.push_back(sent_sum[15:8]);
        frame_q.push_back(sent_sum[7:0]);
        // stray bytes ahead of the newline: one is tolerated, two drop the frame
        if (kind >= 75 && kind < 88) begin
            repeat ((kind >= 83) ? 2 : 1) begin
                stray = 8'($urandom);
                if (stray == TERMINATOR) stray = ~stray;
                frame_q.push_back(stray);
            end
        end
        frame_q.push_back(TERMINATOR);
        foreach (frame_q[i]) send_byte(frame_q[i], 1'b0, NO_RESULT);
        frame_bytes_sent += frame_q.size();
    endtask

    task automatic run_random(input int budget);
        frame_bytes_sent = 0;
        while (frame_bytes_sent < budget) send_random_frame(1'b0);
    endtask

    task automatic check_result(input t_frame_result want);
        if (o_command !== want.command) begin
            $error("command: expected %0h, got %0h", want.command, o_command);
            mismatches++;
        end
        if (o_payload_length !== want.payload_length) begin
            $error("payload_length: expected %0d, got %0d",
                   want.payload_length, o_payload_length);
            mismatches++;
        end
        if (o_payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %0h, got %0h", want.payload_byte, o_payload_byte);
            mismatches++;
        end
        if (o_payload_index !== want.payload_index) begin
            $error("payload_index: expected %0d, got %0d",
                   want.payload_index, o_payload_index);
            mismatches++;
        end
        if (o_last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, o_last);
            mismatches++;
        end
        if (o_checksum_error !== want.checksum_error) begin
            $error("checksum_error: expected %0b, got %0b",
                   want.checksum_error, o_checksum_error);
            mismatches++;
        end
        if (o_computed_sum !== want.computed_sum) begin
            $error("computed_sum: expected %0h, got %0h", want.computed_sum, o_computed_sum);
            mismatches++;
        end
    endtask

    // Result monitor and receiver stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_payload_results.size() == 0) begin
                $error("unexpected result transaction: command %0h, index %0d",
                       o_command, o_payload_index);
                mismatches++;
            end else begin
                check_result(pending_payload_results.pop_front());
            end
        end
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (mode_left == 0) begin
            stall_mode = int'($urandom_range(STALL_NONE, STALL_HEAVY));
            mode_left  = int'($urandom_range(40, 200));
        end else begin
            mode_left--;
        end
        pattern_count++;
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            case (stall_mode)
                STALL_LIGHT:    i_stall <= ($urandom_range(0, 3) == 0);
                STALL_PERIODIC: i_stall <= (pattern_count % 3 == 2);
                STALL_HEAVY:    i_stall <= ($urandom_range(0, 9) < 7);
                default:        i_stall <= 1'b0;
            endcase
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("serial_frame_receiver_unit_tb failed");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: directed table, then random frames with one full drain
        foreach (directed_rows[r]) begin
            send_byte(directed_rows[r].rx_byte, directed_rows[r].typed, directed_rows[r].res);
        end
        run_random(20);
        wait_for_results(0);
        run_random(20);

        // low extremes: any command passes, only empty frames fit
        wait_for_results(IDLE_SLACK);
        apply_config(8'h00, 8'h00, 8'h00, 8'h00);
        run_random(20);

        // high extremes and full-size frames against a long downstream hold-off
        wait_for_results(IDLE_SLACK);
        apply_config(8'hFF, 8'hFF, 8'hFF, 8'd64);
        hold_requests <= hold_requests + 1;
        send_random_frame(1'b1);
        run_random(15);

        // start byte equal to the newline, length limit above the buffer depth
        wait_for_results(IDLE_SLACK);
        apply_config(8'h0A, 8'h0F, 8'h05, 8'hFF);
        send_random_frame(1'b1);
        run_random(10);

        // unmapped indexes are ignored, then a mid-range setting
        wait_for_results(IDLE_SLACK);
        write_reg(CFG_UNMAPPED_LO, 8'($urandom));
        write_reg(CFG_UNMAPPED_HI, 8'($urandom));
        apply_config(8'h5A, 8'hC0, 8'h40, 8'd20);
        run_random(15);

        wait_for_results(DRAIN_CYCLES);
        if (mismatches == 0) begin
            $display("serial_frame_receiver_unit_tb passed");
        end else begin
            $display("serial_frame_receiver_unit_tb failed");
        end
        $finish;
    end

endmodule
